/* design/assert_macros.svh */
// assertion macros shared by the cache rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* design/lru_pkg.sv */
// shared types and constants of the lru lookup cache
// no dependencies
package lru_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 64;
   localparam int FIELD_W        = 64;
   localparam int CAP_W          = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_FILL   = 1'b1;

   localparam logic [1:0] SEL_NONE   = 2'd0;
   localparam logic [1:0] SEL_MATCH  = 2'd1;
   localparam logic [1:0] SEL_VICTIM = 2'd2;
   localparam logic [1:0] SEL_FREE   = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic [FIELD_W-1:0] query_key;
      logic [FIELD_W-1:0] fill_value;
   } lru_req_type;

   typedef struct packed {
      logic               hit;
      logic [FIELD_W-1:0] value_out;
      logic               evicted;
      logic [FIELD_W-1:0] evicted_key;
   } lru_rsp_type;

   typedef struct packed {
      logic       search;
      logic       update;
      logic [1:0] sel;
      logic       write_key;
      logic       write_value;
      logic       age_all;
   } lru_cmd_type;

   typedef struct packed {
      logic hit;
      logic victim;
      logic vacant;
   } lru_link_type;

endpackage

/* design/lru_cell.sv */
// one cache entry: key, value, valid flag and recency rank
// depends on lru_pkg
module lru_cell import lru_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lru_cmd_type           cmd,
   input  logic [KEY_BITS-1:0]   bus_key,
   input  logic [VALUE_BITS-1:0] bus_value,
   input  logic [$clog2(ENTRIES)-1:0] victim_rank,
   input  logic [$clog2(ENTRIES)-1:0] limit,
   input  lru_link_type          up_link,
   input  logic [VALUE_BITS-1:0] up_value,
   input  logic [$clog2(ENTRIES)-1:0] up_rank,
   input  logic [KEY_BITS-1:0]   up_key,
   output lru_link_type          dn_link,
   output logic [VALUE_BITS-1:0] dn_value,
   output logic [$clog2(ENTRIES)-1:0] dn_rank,
   output logic [KEY_BITS-1:0]   dn_key
);

   localparam int RANK_W = $clog2(ENTRIES);

   logic                  valid_ff, valid_in;
   logic                  match_ff, match_in;
   logic                  victim_ff, victim_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   logic                  match_now;
   logic                  victim_now;
   logic                  target;

   assign match_now  = valid_ff && (key_ff == bus_key);
   assign victim_now = valid_ff && (rank_ff == victim_rank);

   // chain towards the tail of the row
   always_comb begin
      dn_link.hit    = up_link.hit | match_now;
      dn_link.victim = up_link.victim | victim_now;
      dn_link.vacant = up_link.vacant | !valid_ff;
      dn_value       = up_value | (match_now ? value_ff : '0);
      dn_rank        = up_rank | (match_now ? rank_ff : '0);
      dn_key         = up_key | (victim_now ? key_ff : '0);
   end

   always_comb begin
      case (cmd.sel)
         SEL_MATCH:  target = match_ff;
         SEL_VICTIM: target = victim_ff;
         SEL_FREE:   target = !valid_ff && !up_link.vacant;
         default:    target = 1'b0;
      endcase
   end

   always_comb begin
      match_in  = cmd.search ? match_now : match_ff;
      victim_in = cmd.search ? victim_now : victim_ff;
      valid_in  = valid_ff;
      key_in    = key_ff;
      value_in  = value_ff;
      rank_in   = rank_ff;
      if (cmd.update) begin
         if (target) begin
            valid_in = 1'b1;
            rank_in  = '0;
            if (cmd.write_key) begin
               key_in = bus_key;
            end
            if (cmd.write_value) begin
               value_in = bus_value;
            end
         end else if (valid_ff && (cmd.age_all || (rank_ff < limit))) begin
            rank_in = RANK_W'(rank_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         match_ff  <= 1'b0;
         victim_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         match_ff  <= match_in;
         victim_ff <= victim_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

endmodule

/* design/lru_row.sv */
// row of cache cells linked head to tail, giving the search summary
// depends on lru_pkg and lru_cell
module lru_row import lru_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lru_cmd_type           cmd,
   input  logic [KEY_BITS-1:0]   bus_key,
   input  logic [VALUE_BITS-1:0] bus_value,
   input  logic [$clog2(ENTRIES)-1:0] victim_rank,
   input  logic [$clog2(ENTRIES)-1:0] limit,
   output lru_link_type          sum_link,
   output logic [VALUE_BITS-1:0] sum_value,
   output logic [$clog2(ENTRIES)-1:0] sum_rank,
   output logic [KEY_BITS-1:0]   sum_key
);

   localparam int RANK_W = $clog2(ENTRIES);

   lru_link_type          link  [ENTRIES+1];
   logic [VALUE_BITS-1:0] value [ENTRIES+1];
   logic [RANK_W-1:0]     rank  [ENTRIES+1];
   logic [KEY_BITS-1:0]   key   [ENTRIES+1];

   assign link[0]  = '0;
   assign value[0] = '0;
   assign rank[0]  = '0;
   assign key[0]   = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lru_cell #(
         .ENTRIES    (ENTRIES),
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .bus_key     (bus_key),
         .bus_value   (bus_value),
         .victim_rank (victim_rank),
         .limit       (limit),
         .up_link     (link[i]),
         .up_value    (value[i]),
         .up_rank     (rank[i]),
         .up_key      (key[i]),
         .dn_link     (link[i+1]),
         .dn_value    (value[i+1]),
         .dn_rank     (rank[i+1]),
         .dn_key      (key[i+1])
      );
   end

   assign sum_link  = link[ENTRIES];
   assign sum_value = value[ENTRIES];
   assign sum_rank  = rank[ENTRIES];
   assign sum_key   = key[ENTRIES];

endmodule

/* design/lru_lookup_cache.sv */
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lru_pkg, lru_row, lru_cell and assert_macros.svh.
//
// Request channel (req_valid/req_ready/req_payload): a lookup (req_type 0)
// returns the stored value on a hit and makes that entry most recent; a
// fill (req_type 1) stores the key and value as most recent, overwriting a
// present key, or evicting the least recent entry once the cache holds
// csr capacity entries, in which case the evicted key is reported.
// Response channel (rsp_valid/rsp_ready/rsp_payload): one item per request,
// in request order. The capacity register is written through csr_wr_en and
// csr_wr_data; the user must write it only while no request is in flight,
// which the block does not enforce. Zero acts as one and values above the
// entry count saturate. Each request first searches the row of cells,
// where every cell compares its key and the match is chained to the tail,
// then updates ranks and contents. The response is valid the cycle after
// the update, and a new request is taken in the update cycle unless the
// response stalls, so the next one is accepted while the last is updated.
// While the receiver stalls the response holds in its output register and
// the next request finishes its search, then waits in its update cycle.
// Synchronous reset empties the cache and sets the capacity to 16.
module lru_lookup_cache import lru_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lru_req_type      req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lru_rsp_type      rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

`include "assert_macros.svh"

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  fill_ff, fill_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  hit_ff, hit_in;
   logic                  found_ff, found_in;
   logic [RANK_W-1:0]     hit_rank_ff, hit_rank_in;
   logic [VALUE_BITS-1:0] hit_value_ff, hit_value_in;
   logic [KEY_BITS-1:0]   victim_key_ff, victim_key_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   lru_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   lru_cmd_type           cmd;
   lru_link_type          sum_link;
   logic [VALUE_BITS-1:0] sum_value;
   logic [RANK_W-1:0]     sum_rank;
   logic [KEY_BITS-1:0]   sum_key;
   logic [RANK_W-1:0]     victim_rank;
   logic [RANK_W-1:0]     limit;
   logic [CMP_W-1:0]      cap_wide;
   logic [CMP_W-1:0]      eff_cap;
   logic                  full;
   logic                  update_fire;
   logic                  req_fire;
   logic                  insert;
   lru_rsp_type           rsp_next;

   assign update_fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = (state_ff == ST_IDLE) || update_fire;
   assign req_fire    = req_valid && req_ready;
   assign victim_rank = RANK_W'(count_ff - 1'b1);

   always_comb begin
      cap_wide = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_wide > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_wide;
      end
      full = CMP_W'(count_ff) >= eff_cap;
   end

   // decide the update from the registered search summary
   always_comb begin
      cmd          = '0;
      limit        = hit_rank_ff;
      insert       = 1'b0;
      rsp_next     = '0;
      rsp_next.hit = hit_ff;
      if (state_ff == ST_SEARCH) begin
         cmd.search = 1'b1;
      end
      if (update_fire) begin
         cmd.update = 1'b1;
         if (fill_ff == REQ_LOOKUP) begin
            cmd.sel = hit_ff ? SEL_MATCH : SEL_NONE;
            if (hit_ff) begin
               rsp_next.value_out = FIELD_W'(hit_value_ff);
            end
         end else if (hit_ff) begin
            cmd.sel         = SEL_MATCH;
            cmd.write_value = 1'b1;
         end else if (full && found_ff) begin
            cmd.sel              = SEL_VICTIM;
            cmd.write_key        = 1'b1;
            cmd.write_value      = 1'b1;
            limit                = victim_rank;
            rsp_next.evicted     = 1'b1;
            rsp_next.evicted_key = FIELD_W'(victim_key_ff);
         end else begin
            cmd.sel         = SEL_FREE;
            cmd.write_key   = 1'b1;
            cmd.write_value = 1'b1;
            cmd.age_all     = 1'b1;
            insert          = 1'b1;
         end
      end
   end

   lru_row #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_row (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .bus_key     (key_ff),
      .bus_value   (value_ff),
      .victim_rank (victim_rank),
      .limit       (limit),
      .sum_link    (sum_link),
      .sum_value   (sum_value),
      .sum_rank    (sum_rank),
      .sum_key     (sum_key)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (req_fire) begin
               state_in = ST_SEARCH;
            end else if (update_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      fill_in       = req_fire ? req_payload.req_type : fill_ff;
      key_in        = req_fire ? req_payload.query_key[KEY_BITS-1:0] : key_ff;
      value_in      = req_fire ? req_payload.fill_value[VALUE_BITS-1:0] : value_ff;
      hit_in        = cmd.search ? sum_link.hit : hit_ff;
      found_in      = cmd.search ? sum_link.victim : found_ff;
      hit_rank_in   = cmd.search ? sum_rank : hit_rank_ff;
      hit_value_in  = cmd.search ? sum_value : hit_value_ff;
      victim_key_in = cmd.search ? sum_key : victim_key_ff;
      count_in      = insert ? CNT_W'(count_ff + 1'b1) : count_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_in        = update_fire ? rsp_next : rsp_ff;
      rsp_valid_in  = update_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff       <= fill_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      hit_ff        <= hit_in;
      found_ff      <= found_in;
      hit_rank_ff   <= hit_rank_in;
      hit_value_ff  <= hit_value_in;
      victim_key_ff <= victim_key_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_CLK(a_accept_searches, clock, reset, req_fire |=> (state_ff == ST_SEARCH), "accepted item did not start a search")
   `ASSERT_CLK(a_free_slot, clock, reset, (cmd.update && (cmd.sel == SEL_FREE)) |-> sum_link.vacant, "insert with no free cell")
   `ASSERT_CLK(a_lookup_count, clock, reset, (update_fire && (fill_ff == REQ_LOOKUP)) |=> (count_ff == $past(count_ff)), "lookup changed the entry count")
   `ASSERT_NEVER(a_count_bound, clock, reset, CMP_W'(count_ff) > CMP_W'(ENTRIES), "entry count above the number of cells")

endmodule
